[src/gelp_pkg.sv]
// Shared types and character constants for the graph edge list text parser.
package gelp_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_SEEK,
        MODE_NUM1,
        MODE_NUM2,
        MODE_SKIP_EOL
    } mode_t;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_C    = 8'h63;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_E    = 8'h65;
    localparam logic [7:0] CH_NL   = 8'h0A;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_EDGE   = 1'b1;

endpackage

[src/gelp_digit_acc.sv]
// Saturating decimal accumulator step: acc * 10 + digit, clamped to all ones.
module gelp_digit_acc #(
    parameter int VALUE_BITS = 31
) (
    input  logic [VALUE_BITS-1:0] acc,
    input  logic [7:0]            ch,
    output logic [VALUE_BITS-1:0] acc_out
);

    logic [VALUE_BITS+3:0] times8;
    logic [VALUE_BITS+3:0] times2;
    logic [VALUE_BITS+3:0] digit;
    logic [VALUE_BITS+3:0] sum;

    // The digit value is the low nibble, since '0' sits at 0x30.
    assign times8  = {1'b0, acc, 3'b000};
    assign times2  = {3'b000, acc, 1'b0};
    assign digit   = {{VALUE_BITS{1'b0}}, ch[3:0]};
    assign sum     = times8 + times2 + digit;
    assign acc_out = (sum[VALUE_BITS+3:VALUE_BITS] != 4'd0) ? {VALUE_BITS{1'b1}}
                                                            : sum[VALUE_BITS-1:0];

endmodule

[src/graph_edge_list_text_parser_top.sv]
// Top level of the graph edge list text parser (byte stream in, header/edge records out).
// Throughput: one byte per cycle unless stalled, set by the mode and number update.
// A newline that ends a line waits in the input register until the result register is free;
// it is processed then, and its record is valid in the result register from that edge on.
// Reset (rst_n, asynchronous, active low) returns the parser to idle, clears the numbers
// and the edge counter, and empties both the input and the result register.
module graph_edge_list_text_parser_top #(
    parameter int VALUE_BITS = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Byte channel.
    input  logic                  char_valid,
    output logic                  char_stall,
    input  logic [7:0]            char_in,
    // Record channel.
    output logic                  rec_valid,
    input  logic                  rec_stall,
    output logic                  record_kind,
    output logic [VALUE_BITS-1:0] first_value,
    output logic [VALUE_BITS-1:0] second_value,
    output logic [VALUE_BITS-1:0] edge_index
);

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

    // Input register: holds one byte until the parser can take it.
    logic                  char_valid_reg;
    logic                  char_valid_next;
    logic [7:0]            char_reg;

    // Parser state.
    gelp_pkg::mode_t       mode_reg;
    gelp_pkg::mode_t       mode_next;
    logic                  kind_reg;
    logic                  kind_next;
    logic [VALUE_BITS-1:0] num1_reg;
    logic [VALUE_BITS-1:0] num1_next;
    logic [VALUE_BITS-1:0] num2_reg;
    logic [VALUE_BITS-1:0] num2_next;
    logic [VALUE_BITS-1:0] edge_cnt_reg;
    logic [VALUE_BITS-1:0] edge_cnt_next;

    // Result register.
    logic                  rec_valid_reg;
    logic                  rec_valid_next;
    logic                  rec_kind_reg;
    logic [VALUE_BITS-1:0] rec_first_reg;
    logic [VALUE_BITS-1:0] rec_second_reg;
    logic [VALUE_BITS-1:0] rec_index_reg;

    logic                  advance;
    logic                  char_accept;
    logic                  proc_fire;
    logic                  is_digit;
    logic                  is_nl;
    logic                  emit;
    logic [VALUE_BITS-1:0] acc_src;
    logic [VALUE_BITS-1:0] acc_new;

    // The result register can take a new record when it is empty or its record leaves
    // this cycle. The byte in the input register is processed exactly then, so the two
    // sides are decoupled by one register each; unless stalled, one byte flows per cycle.
    assign advance     = !rec_valid_reg || !rec_stall;
    assign proc_fire   = char_valid_reg && advance;
    assign char_stall  = char_valid_reg && !advance;
    assign char_accept = char_valid && !char_stall;

    assign is_digit = (char_reg >= gelp_pkg::CH_ZERO) && (char_reg <= gelp_pkg::CH_NINE);
    assign is_nl    = (char_reg == gelp_pkg::CH_NL);

    // One shared multiply-by-ten unit serves both numbers; the first digit of
    // number one starts from zero.
    always_comb
    begin
        case (mode_reg)
            gelp_pkg::MODE_NUM1: acc_src = num1_reg;
            gelp_pkg::MODE_NUM2: acc_src = num2_reg;
            default:             acc_src = '0;
        endcase
    end

    gelp_digit_acc #(
        .VALUE_BITS (VALUE_BITS)
    ) u_digit_acc (
        .acc     (acc_src),
        .ch      (char_reg),
        .acc_out (acc_new)
    );

    // Next-state logic of the line parser.
    always_comb
    begin
        mode_next = mode_reg;
        if (proc_fire)
        begin
            case (mode_reg)
                gelp_pkg::MODE_IDLE:
                begin
                    if (char_reg == gelp_pkg::CH_C)
                        mode_next = gelp_pkg::MODE_COMMENT;
                    else if (char_reg == gelp_pkg::CH_P || char_reg == gelp_pkg::CH_E)
                        mode_next = gelp_pkg::MODE_SEEK;
                end
                gelp_pkg::MODE_COMMENT:
                begin
                    if (is_nl)
                        mode_next = gelp_pkg::MODE_IDLE;
                end
                gelp_pkg::MODE_SEEK:
                begin
                    if (is_digit)
                        mode_next = gelp_pkg::MODE_NUM1;
                end
                gelp_pkg::MODE_NUM1:
                begin
                    // Any non-digit ends number one and is dropped, newline included.
                    if (!is_digit)
                        mode_next = gelp_pkg::MODE_NUM2;
                end
                gelp_pkg::MODE_NUM2:
                begin
                    if (is_nl)
                        mode_next = gelp_pkg::MODE_IDLE;
                    else if (!is_digit)
                        mode_next = gelp_pkg::MODE_SKIP_EOL;
                end
                gelp_pkg::MODE_SKIP_EOL:
                begin
                    if (is_nl)
                        mode_next = gelp_pkg::MODE_IDLE;
                end
                default:
                    mode_next = gelp_pkg::MODE_IDLE;
            endcase
        end
    end

    // Datapath and record emission.
    always_comb
    begin
        kind_next     = kind_reg;
        num1_next     = num1_reg;
        num2_next     = num2_reg;
        edge_cnt_next = edge_cnt_reg;
        emit          = 1'b0;
        if (proc_fire)
        begin
            case (mode_reg)
                gelp_pkg::MODE_IDLE:
                begin
                    if (char_reg == gelp_pkg::CH_P || char_reg == gelp_pkg::CH_E)
                    begin
                        kind_next = (char_reg == gelp_pkg::CH_E) ? gelp_pkg::KIND_EDGE
                                                                 : gelp_pkg::KIND_HEADER;
                        num1_next = '0;
                        num2_next = '0;
                    end
                end
                gelp_pkg::MODE_SEEK,
                gelp_pkg::MODE_NUM1:
                begin
                    if (is_digit)
                        num1_next = acc_new;
                end
                gelp_pkg::MODE_NUM2:
                begin
                    if (is_digit)
                        num2_next = acc_new;
                    else if (is_nl)
                        emit = 1'b1;
                end
                gelp_pkg::MODE_SKIP_EOL:
                begin
                    if (is_nl)
                        emit = 1'b1;
                end
                default:
                    emit = 1'b0;
            endcase
            // Only edge records advance the counter, which sticks at its top value.
            if (emit && kind_reg == gelp_pkg::KIND_EDGE && edge_cnt_reg != VALUE_MAX)
                edge_cnt_next = edge_cnt_reg + VALUE_BITS'(1);
        end
    end

    assign char_valid_next = char_accept ? 1'b1 : (proc_fire ? 1'b0 : char_valid_reg);
    assign rec_valid_next  = advance ? (proc_fire && emit) : rec_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
            mode_reg       <= gelp_pkg::MODE_IDLE;
            kind_reg       <= gelp_pkg::KIND_HEADER;
            num1_reg       <= '0;
            num2_reg       <= '0;
            edge_cnt_reg   <= '0;
            rec_valid_reg  <= 1'b0;
        end
        else
        begin
            char_valid_reg <= char_valid_next;
            mode_reg       <= mode_next;
            kind_reg       <= kind_next;
            num1_reg       <= num1_next;
            num2_reg       <= num2_next;
            edge_cnt_reg   <= edge_cnt_next;
            rec_valid_reg  <= rec_valid_next;
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge clk)
    begin
        if (char_accept)
            char_reg <= char_in;
        if (proc_fire && emit)
        begin
            rec_kind_reg   <= kind_reg;
            rec_first_reg  <= num1_reg;
            rec_second_reg <= num2_reg;
            rec_index_reg  <= (kind_reg == gelp_pkg::KIND_EDGE) ? edge_cnt_reg : '0;
        end
    end

    assign rec_valid    = rec_valid_reg;
    assign record_kind  = rec_kind_reg;
    assign first_value  = rec_first_reg;
    assign second_value = rec_second_reg;
    assign edge_index   = rec_index_reg;

    // A header record always reports edge index zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid_reg && rec_kind_reg == gelp_pkg::KIND_HEADER |-> rec_index_reg == '0)
        else $error("header record with nonzero edge index");

    // Records come only from the second-number or skip-to-end modes.
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && emit |->
            (mode_reg == gelp_pkg::MODE_NUM2 || mode_reg == gelp_pkg::MODE_SKIP_EOL))
        else $error("record emitted from an unexpected parse mode");

    // After a record the parser is back in idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && emit |=> mode_reg == gelp_pkg::MODE_IDLE)
        else $error("parser not idle after record");

    // The edge counter never goes down.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> edge_cnt_reg >= $past(edge_cnt_reg))
        else $error("edge counter decreased");

    // A byte is never processed while the result register is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid_reg && rec_stall |=> rec_valid_reg && $stable(rec_first_reg))
        else $error("blocked record lost or overwritten");

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the graph edge list text parser: directed text lines, then random lines.
`timescale 1ns / 1ps

module tb_top;

    localparam int VB = 31;
    localparam longint unsigned VALUE_MAX = (64'd1 << VB) - 1;
    localparam int RANDOM_CHARS = 1600;

    // One record as it leaves the parser.
    typedef struct packed {
        logic          kind;
        logic [VB-1:0] value_a;
        logic [VB-1:0] value_b;
        logic [VB-1:0] position;
    } parse_record_t;

    // One row of the directed table. When typed is set, the record that the
    // line produces is written out here; otherwise the predictor supplies it.
    typedef struct {
        string           text;
        bit              typed;
        logic            kind;
        longint unsigned value_a;
        longint unsigned value_b;
        longint unsigned position;
    } directed_line_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          char_valid = 1'b0;
    logic          char_stall;
    logic [7:0]    char_in = 8'h00;
    logic          rec_valid;
    logic          rec_stall = 1'b0;
    logic          record_kind;
    logic [VB-1:0] first_value;
    logic [VB-1:0] second_value;
    logic [VB-1:0] edge_index;

    // Idle and stall rates in percent. They change between the three phases.
    int unsigned sender_idle_pct = 7;
    int unsigned receiver_stall_pct = 65;

    int unsigned chars_sent = 0;
    int unsigned mismatches = 0;

    // Records that the parser still owes us, oldest first.
    parse_record_t expected_records[$];

    // The predictor's own copy of the parser state.
    gelp_pkg::mode_t scan_mode = gelp_pkg::MODE_IDLE;
    logic            line_is_edge = gelp_pkg::KIND_HEADER;
    longint unsigned acc_first = 0;
    longint unsigned acc_second = 0;
    longint unsigned edges_seen = 0;

    // The directed lines. The first two produce nothing: stray bytes in idle
    // (the top byte value, a newline and both neighbors of the digit range),
    // and a comment whose body holds record letters and digits. Then come a
    // header, an edge whose number one follows a newline and is ended by a
    // newline (so the record runs across lines and has no second number), a
    // plain edge, an edge whose first number saturates, a second header that
    // leaves the edge position alone, and one more edge.
    directed_line_t directed_lines [8] = '{
        '{"\377\n:/ ", 1'b0, gelp_pkg::KIND_HEADER, 0, 0, 0},
        '{"cpe 12\n", 1'b0, gelp_pkg::KIND_HEADER, 0, 0, 0},
        '{"p3 4\n", 1'b1, gelp_pkg::KIND_HEADER, 3, 4, 0},
        '{"e\n1\n\n", 1'b1, gelp_pkg::KIND_EDGE, 1, 0, 0},
        '{"e12/3x\n", 1'b0, gelp_pkg::KIND_HEADER, 0, 0, 0},
        '{"e9999999999:0\n", 1'b1, gelp_pkg::KIND_EDGE, VALUE_MAX, 0, 2},
        '{"p0 0\n", 1'b1, gelp_pkg::KIND_HEADER, 0, 0, 0},
        '{"e7 8\n", 1'b0, gelp_pkg::KIND_HEADER, 0, 0, 0}
    };

    graph_edge_list_text_parser_top #(
        .VALUE_BITS(VB)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_in     (char_in),
        .rec_valid   (rec_valid),
        .rec_stall   (rec_stall),
        .record_kind (record_kind),
        .first_value (first_value),
        .second_value(second_value),
        .edge_index  (edge_index)
    );

    always #6 clk = ~clk;

    // Appends one decimal digit to a number and clamps it at the top of the range.
    function automatic longint unsigned append_digit(input longint unsigned acc,
                                                     input logic [7:0] ch);
        longint unsigned digit;
        digit = longint'(ch - gelp_pkg::CH_ZERO);
        if (acc > (VALUE_MAX - digit) / 10)
            return VALUE_MAX;
        return acc * 10 + digit;
    endfunction

    function automatic bit is_digit(input logic [7:0] ch);
        return ch >= gelp_pkg::CH_ZERO && ch <= gelp_pkg::CH_NINE;
    endfunction

    // Builds the record for the line that a newline has just closed. Only
    // edge records advance the position, and it sticks at the top of the range.
    function automatic parse_record_t close_line();
        parse_record_t rec;
        rec.kind     = line_is_edge;
        rec.value_a  = acc_first[VB-1:0];
        rec.value_b  = acc_second[VB-1:0];
        rec.position = '0;
        if (line_is_edge == gelp_pkg::KIND_EDGE)
        begin
            rec.position = edges_seen[VB-1:0];
            if (edges_seen < VALUE_MAX)
                edges_seen++;
        end
        scan_mode = gelp_pkg::MODE_IDLE;
        return rec;
    endfunction

    // Advances the predicted parser by one byte. Returns 1 when the byte
    // completes a record, which is then left in rec.
    function automatic bit parse_byte(input logic [7:0] ch, output parse_record_t rec);
        rec = '0;
        case (scan_mode)
            gelp_pkg::MODE_IDLE:
                if (ch == gelp_pkg::CH_C)
                begin
                    scan_mode = gelp_pkg::MODE_COMMENT;
                end
                else if (ch == gelp_pkg::CH_P || ch == gelp_pkg::CH_E)
                begin
                    line_is_edge = (ch == gelp_pkg::CH_E) ? gelp_pkg::KIND_EDGE
                                                          : gelp_pkg::KIND_HEADER;
                    acc_first    = 0;
                    acc_second   = 0;
                    scan_mode    = gelp_pkg::MODE_SEEK;
                end
            gelp_pkg::MODE_COMMENT:
                if (ch == gelp_pkg::CH_NL)
                    scan_mode = gelp_pkg::MODE_IDLE;
            gelp_pkg::MODE_SEEK:
                if (is_digit(ch))
                begin
                    acc_first = append_digit(0, ch);
                    scan_mode = gelp_pkg::MODE_NUM1;
                end
            gelp_pkg::MODE_NUM1:
                // Whatever byte ends number one is swallowed, newline or not.
                if (is_digit(ch))
                    acc_first = append_digit(acc_first, ch);
                else
                    scan_mode = gelp_pkg::MODE_NUM2;
            gelp_pkg::MODE_NUM2:
                if (is_digit(ch))
                begin
                    acc_second = append_digit(acc_second, ch);
                end
                else if (ch == gelp_pkg::CH_NL)
                begin
                    rec = close_line();
                    return 1'b1;
                end
                else
                begin
                    scan_mode = gelp_pkg::MODE_SKIP_EOL;
                end
            gelp_pkg::MODE_SKIP_EOL:
                if (ch == gelp_pkg::CH_NL)
                begin
                    rec = close_line();
                    return 1'b1;
                end
            default:
                scan_mode = gelp_pkg::MODE_IDLE;
        endcase
        return 1'b0;
    endfunction

    // Offers one byte, with a random gap in front, and waits for its transfer.
    // The predictor always sees the byte; its record is queued only when asked.
    task automatic send_char(input logic [7:0] ch, input bit predict);
        parse_record_t rec;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_in    <= ch;
        do
            @(posedge clk);
        while (char_stall);
        chars_sent++;
        if (parse_byte(ch, rec) && predict)
            expected_records.push_back(rec);
    endtask

    task automatic send_text(input string text, input bit predict);
        for (int i = 0; i < text.len(); i++)
            send_char(text[i], predict);
    endtask

    // A decimal number: mostly short, sometimes long enough to saturate, and
    // now and then right at the edge of the range. Leading zeros are allowed.
    function automatic string random_number();
        int unsigned digits;
        string s;
        case ($urandom_range(0, 19))
            0: return "2147483647";
            1: return "2147483648";
            2, 3: digits = $urandom_range(9, 14);
            default: digits = $urandom_range(1, 4);
        endcase
        s = "";
        repeat (digits)
            s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        return s;
    endfunction

    // A byte that is not a digit: usually a space, sometimes any other byte,
    // and a newline where the caller allows one.
    function automatic logic [7:0] random_separator(input bit allow_nl);
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0: if (allow_nl) return gelp_pkg::CH_NL;
            1, 2:
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (is_digit(b) || b == gelp_pkg::CH_NL);
                    return b;
                end
            default: ;
        endcase
        return 8'h20;
    endfunction

    // Any byte but a newline, for comment bodies and line tails.
    function automatic logic [7:0] random_filler();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == gelp_pkg::CH_NL);
        return b;
    endfunction

    // One random line. Most are well-formed header or edge lines with random
    // separators, numbers and tails; some are comments and some are raw noise
    // that can leave the parser in the middle of a record.
    task automatic send_random_line();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            send_char(gelp_pkg::CH_C, 1'b1);
            repeat ($urandom_range(0, 6))
                send_char(random_filler(), 1'b1);
            send_char(gelp_pkg::CH_NL, 1'b1);
        end
        else if (pick < 88)
        begin
            send_char(($urandom_range(0, 3) == 0) ? gelp_pkg::CH_P : gelp_pkg::CH_E, 1'b1);
            repeat ($urandom_range(0, 2))
                send_char(random_separator(1'b1), 1'b1);
            send_text(random_number(), 1'b1);
            send_char(random_separator(1'b1), 1'b1);
            if ($urandom_range(0, 4) != 0)
                send_text(random_number(), 1'b1);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4))
                    send_char(random_filler(), 1'b1);
            send_char(gelp_pkg::CH_NL, 1'b1);
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                send_char(8'($urandom_range(0, 255)), 1'b1);
            if ($urandom_range(0, 1) == 0)
                send_char(gelp_pkg::CH_NL, 1'b1);
        end
    endtask

    // The record side stalls at random, at the rate of the current phase.
    always @(posedge clk)
        rec_stall <= ($urandom_range(0, 99) < receiver_stall_pct);

    function automatic void check_field(input string name, input logic [VB-1:0] want,
                                        input logic [VB-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Every record transfer is matched against the oldest expectation.
    always @(posedge clk)
    begin
        parse_record_t want;
        if (rst_n && rec_valid && !rec_stall)
        begin
            if (expected_records.size() == 0)
            begin
                $display("%0t ns: unexpected record, expected none, got kind %0d (%0d, %0d, %0d)",
                         $time, record_kind, first_value, second_value, edge_index);
                mismatches++;
            end
            else
            begin
                want = expected_records.pop_front();
                check_field("record_kind", VB'(want.kind), VB'(record_kind));
                check_field("first_value", want.value_a, first_value);
                check_field("second_value", want.value_b, second_value);
                check_field("edge_index", want.position, edge_index);
            end
        end
    end

    initial
    begin
        parse_record_t typed_rec;
        int unsigned random_start;
        int unsigned random_done;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The lowest byte value goes first; idle ignores it.
        send_char(8'h00, 1'b1);
        foreach (directed_lines[i])
        begin
            send_text(directed_lines[i].text, !directed_lines[i].typed);
            if (directed_lines[i].typed)
            begin
                typed_rec.kind     = directed_lines[i].kind;
                typed_rec.value_a  = directed_lines[i].value_a[VB-1:0];
                typed_rec.value_b  = directed_lines[i].value_b[VB-1:0];
                typed_rec.position = directed_lines[i].position[VB-1:0];
                expected_records.push_back(typed_rec);
            end
        end

        // Random part in three phases: a busy sender against a stalling
        // receiver, then the reverse, then full speed on both sides.
        random_start = chars_sent;
        random_done  = 0;
        while (random_done < RANDOM_CHARS)
        begin
            case (random_done * 3 / RANDOM_CHARS)
                0:
                begin
                    sender_idle_pct = 7;
                    receiver_stall_pct = 65;
                end
                1:
                begin
                    sender_idle_pct = 65;
                    receiver_stall_pct = 7;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            send_random_line();
            random_done = chars_sent - random_start;
        end
        char_valid <= 1'b0;

        // Drain, then give a late or surplus record time to show up.
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: a correct run needs only a small fraction of this.
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
